// ===== rtl/core/nbe_pkg.sv =====
// shared types, sizes and helpers of the board evaluator
package nbe_pkg;

  localparam int FEATURE_COUNT = 768;
  localparam int HIDDEN_ONE    = 256;
  localparam int HIDDEN_TWO    = 32;
  localparam int ACTIVE_LIMIT  = 32;
  localparam int SCORE_SCALE   = 400;
  localparam int FRAC_BITS     = 12;
  localparam int ACT_MAX       = 4096;
  localparam int SCORE_LIMIT   = 32767;

  localparam int ROW_W   = 10;
  localparam int H1_W    = 8;
  localparam int H2_W    = 5;
  localparam int IW_AW   = 18;
  localparam int W2_AW   = 13;
  localparam int CNT_W   = 6;
  localparam int ACT_W   = 13;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = 2;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_FEATURE = 2'd1;
  localparam logic [1:0] CMD_EVAL    = 2'd2;

  localparam logic [2:0] SEL_IW = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_W2 = 3'd2;
  localparam logic [2:0] SEL_B2 = 3'd3;
  localparam logic [2:0] SEL_OW = 3'd4;
  localparam logic [2:0] SEL_OB = 3'd5;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_FEATURE,
    OP_EVAL
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [2:0]         sel;
    logic [IW_AW-1:0]   idx;
    logic signed [15:0] value;
    logic [ROW_W-1:0]   row;
    logic               black;
    logic               ready;
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FEAT,
    B_H1,
    B_L2,
    B_OUT,
    B_SCALE,
    B_SAT
  } back_state_t;

  // clipped relu to 0..4096
  function automatic logic [ACT_W-1:0] clip_act(input logic signed [33:0] v);
    logic [ACT_W-1:0] r;
    if (v < 34'sd0) begin
      r = '0;
    end else if (v > 34'(ACT_MAX)) begin
      r = ACT_W'(ACT_MAX);
    end else begin
      r = v[ACT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/nbe_front.sv =====
// front end: accepts items, drops ignored ones, tracks the feature count
module nbe_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           command,
  input  logic [2:0]           table_select,
  input  logic [17:0]          weight_index,
  input  logic signed [15:0]   weight_value,
  input  logic [3:0]           piece,
  input  logic [5:0]           square,
  input  logic                 side_to_move,
  input  logic                 weights_ready,
  input  logic                 q_full,
  output logic                 push,
  output nbe_pkg::op_t         op
);

  localparam logic [nbe_pkg::ROW_W-1:0] ROW_LIMIT = nbe_pkg::ROW_W'(nbe_pkg::FEATURE_COUNT);

  logic [nbe_pkg::CNT_W-1:0] active_count;
  logic                      accept;
  logic                      wr_ok;
  logic                      feat_ok;
  logic [nbe_pkg::ROW_W-1:0] row;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign row      = {piece, square};

  // range checks on writes and features
  always_comb begin
    unique case (table_select)
      nbe_pkg::SEL_IW: wr_ok = weight_index <
                               18'(nbe_pkg::FEATURE_COUNT * nbe_pkg::HIDDEN_ONE);
      nbe_pkg::SEL_B1: wr_ok = weight_index < 18'(nbe_pkg::HIDDEN_ONE);
      nbe_pkg::SEL_W2: wr_ok = weight_index <
                               18'(nbe_pkg::HIDDEN_ONE * nbe_pkg::HIDDEN_TWO);
      nbe_pkg::SEL_B2: wr_ok = weight_index < 18'(nbe_pkg::HIDDEN_TWO);
      nbe_pkg::SEL_OW: wr_ok = weight_index < 18'(nbe_pkg::HIDDEN_TWO);
      nbe_pkg::SEL_OB: wr_ok = weight_index == 18'd0;
      default:         wr_ok = 1'b0;
    endcase
    feat_ok = (row < ROW_LIMIT) &&
              (active_count < nbe_pkg::CNT_W'(nbe_pkg::ACTIVE_LIMIT));
  end

  // classify into a queue op
  always_comb begin
    op.sel   = table_select;
    op.idx   = weight_index;
    op.value = weight_value;
    op.row   = row;
    op.black = side_to_move;
    op.ready = weights_ready;
    push     = 1'b0;
    op.kind  = nbe_pkg::OP_WRITE;
    unique case (command)
      nbe_pkg::CMD_WRITE: begin
        op.kind = nbe_pkg::OP_WRITE;
        push    = accept && wr_ok;
      end
      nbe_pkg::CMD_FEATURE: begin
        op.kind = nbe_pkg::OP_FEATURE;
        push    = accept && feat_ok;
      end
      nbe_pkg::CMD_EVAL: begin
        op.kind = nbe_pkg::OP_EVAL;
        push    = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // feature count, cleared by evaluate
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= '0;
    end else if (accept && command == nbe_pkg::CMD_FEATURE && feat_ok) begin
      active_count <= active_count + 1'b1;
    end else if (accept && command == nbe_pkg::CMD_EVAL) begin
      active_count <= '0;
    end
  end

endmodule

// ===== rtl/core/nbe_queue.sv =====
// short op queue between front and back
module nbe_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  nbe_pkg::op_t op_in,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output nbe_pkg::op_t op_out
);

  nbe_pkg::op_t               entries [nbe_pkg::QUEUE_DEPTH];
  logic [nbe_pkg::QPTR_W-1:0] wr_ptr;
  logic [nbe_pkg::QPTR_W-1:0] rd_ptr;
  logic [nbe_pkg::QPTR_W:0]   fill;

  assign full   = fill == (nbe_pkg::QPTR_W+1)'(nbe_pkg::QUEUE_DEPTH);
  assign valid  = fill != '0;
  assign op_out = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= op_in;
    end
  end

endmodule

// ===== rtl/core/nbe_back.sv =====
// back end: weight memories, feature sum and the shared multiply-accumulate
module nbe_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  nbe_pkg::op_t        q_op,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  score
);

  localparam logic [nbe_pkg::H1_W-1:0] J_MAX = nbe_pkg::H1_W'(nbe_pkg::HIDDEN_ONE - 1);
  localparam logic [nbe_pkg::H2_W-1:0] I_MAX = nbe_pkg::H2_W'(nbe_pkg::HIDDEN_TWO - 1);

  // memories
  logic signed [15:0] iw_mem [nbe_pkg::FEATURE_COUNT * nbe_pkg::HIDDEN_ONE];
  logic signed [15:0] b1_mem [nbe_pkg::HIDDEN_ONE];
  logic signed [15:0] w2_mem [nbe_pkg::HIDDEN_ONE * nbe_pkg::HIDDEN_TWO];
  logic signed [15:0] b2_mem [nbe_pkg::HIDDEN_TWO];
  logic signed [15:0] ow_mem [nbe_pkg::HIDDEN_TWO];
  logic signed [15:0] ob;
  logic signed [31:0] fs_mem [nbe_pkg::HIDDEN_ONE];
  logic [nbe_pkg::HIDDEN_ONE-1:0] fs_vld;
  logic [nbe_pkg::ACT_W-1:0] h1_mem [nbe_pkg::HIDDEN_ONE];
  logic [nbe_pkg::ACT_W-1:0] h2 [nbe_pkg::HIDDEN_TWO];

  // control
  nbe_pkg::back_state_t state, state_next;
  logic [nbe_pkg::H1_W-1:0]  j, j_next;
  logic [nbe_pkg::H2_W-1:0]  i, i_next;
  logic                      issue_end, issue_end_next;
  logic                      iss, iss_first, iss_last;
  logic [nbe_pkg::ROW_W-1:0] row;
  logic                      ev_black;
  logic                      ev_ready;
  logic                      wr_en;
  logic                      load_out;
  logic                      pipe_busy;

  // read data stage
  logic signed [15:0]        iw_q, b1_q, w2_q, b2_q, ow_q;
  logic signed [31:0]        fs_q;
  logic                      fs_vq;
  logic [nbe_pkg::ACT_W-1:0] h1_q, h2_q;
  logic                      p1_v, p1_first, p1_last;
  logic [nbe_pkg::H1_W-1:0]  p1_j;
  logic [nbe_pkg::H2_W-1:0]  p1_i;

  // product stage
  logic signed [29:0]        p2_prod;
  logic signed [15:0]        p2_bias;
  logic                      p2_v, p2_first, p2_last;
  logic [nbe_pkg::H2_W-1:0]  p2_i;

  // accumulate and scale
  logic signed [31:0] acc;
  logic signed [31:0] mac_sum;
  logic signed [31:0] out_val;
  logic signed [42:0] prod_s;
  logic signed [42:0] q_div;
  logic signed [15:0] score_next;
  logic signed [31:0] fs_base;
  logic [nbe_pkg::ACT_W-1:0] op_a;
  logic signed [15:0] op_b;

  assign pipe_busy = p1_v || p2_v;
  assign wr_en     = (state == nbe_pkg::B_IDLE) && q_valid && (q_op.kind == nbe_pkg::OP_WRITE);
  assign fs_base   = fs_vq ? fs_q : 32'sd0;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= nbe_pkg::B_IDLE;
      j         <= '0;
      i         <= '0;
      issue_end <= 1'b0;
    end else begin
      state     <= state_next;
      j         <= j_next;
      i         <= i_next;
      issue_end <= issue_end_next;
    end
  end

  // next state and issue control
  always_comb begin
    state_next     = state;
    j_next         = j;
    i_next         = i;
    issue_end_next = issue_end;
    iss            = 1'b0;
    iss_first      = 1'b0;
    iss_last       = 1'b0;
    pop            = 1'b0;
    load_out       = 1'b0;
    unique case (state)
      nbe_pkg::B_IDLE: begin
        if (q_valid) begin
          pop    = 1'b1;
          j_next = '0;
          i_next = '0;
          unique case (q_op.kind)
            nbe_pkg::OP_FEATURE: state_next = nbe_pkg::B_FEAT;
            nbe_pkg::OP_EVAL:    state_next = q_op.ready ? nbe_pkg::B_H1 : nbe_pkg::B_SAT;
            default:             state_next = nbe_pkg::B_IDLE;
          endcase
        end
      end
      nbe_pkg::B_FEAT, nbe_pkg::B_H1: begin
        if (!issue_end) begin
          iss            = 1'b1;
          iss_last       = j == J_MAX;
          j_next         = j + 1'b1;
          issue_end_next = iss_last;
        end else if (!pipe_busy) begin
          issue_end_next = 1'b0;
          state_next     = (state == nbe_pkg::B_FEAT) ? nbe_pkg::B_IDLE : nbe_pkg::B_L2;
        end
      end
      nbe_pkg::B_L2: begin
        if (!issue_end) begin
          iss       = 1'b1;
          iss_first = j == '0;
          iss_last  = j == J_MAX;
          j_next    = j + 1'b1;
          if (iss_last) begin
            i_next         = i + 1'b1;
            issue_end_next = i == I_MAX;
          end
        end else if (!pipe_busy) begin
          issue_end_next = 1'b0;
          i_next         = '0;
          state_next     = nbe_pkg::B_OUT;
        end
      end
      nbe_pkg::B_OUT: begin
        if (!issue_end) begin
          iss            = 1'b1;
          iss_first      = i == '0;
          iss_last       = i == I_MAX;
          i_next         = i + 1'b1;
          issue_end_next = iss_last;
        end else if (!pipe_busy) begin
          issue_end_next = 1'b0;
          state_next     = nbe_pkg::B_SCALE;
        end
      end
      nbe_pkg::B_SCALE: begin
        state_next = nbe_pkg::B_SAT;
      end
      nbe_pkg::B_SAT: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = nbe_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = nbe_pkg::B_IDLE;
      end
    endcase
  end

  // capture the op being started
  always_ff @(posedge clk) begin
    if (pop) begin
      row      <= q_op.row;
      ev_black <= q_op.black;
      ev_ready <= q_op.ready;
    end
  end

  // weight writes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (q_op.sel)
        nbe_pkg::SEL_IW: iw_mem[q_op.idx] <= q_op.value;
        nbe_pkg::SEL_B1: b1_mem[q_op.idx[nbe_pkg::H1_W-1:0]] <= q_op.value;
        nbe_pkg::SEL_W2: w2_mem[q_op.idx[nbe_pkg::W2_AW-1:0]] <= q_op.value;
        nbe_pkg::SEL_B2: b2_mem[q_op.idx[nbe_pkg::H2_W-1:0]] <= q_op.value;
        nbe_pkg::SEL_OW: ow_mem[q_op.idx[nbe_pkg::H2_W-1:0]] <= q_op.value;
        nbe_pkg::SEL_OB: ob <= q_op.value;
        default: ;
      endcase
    end
  end

  // registered memory reads at the issue counters
  always_ff @(posedge clk) begin
    iw_q <= iw_mem[{row, j}];
    fs_q <= fs_mem[j];
    b1_q <= b1_mem[j];
    h1_q <= h1_mem[j];
    w2_q <= w2_mem[{j, i}];
    b2_q <= b2_mem[i];
    ow_q <= ow_mem[i];
    h2_q <= h2[i];
    fs_vq <= fs_vld[j];
    p1_j <= j;
    p1_i <= i;
    p1_first <= iss_first;
    p1_last  <= iss_last;
  end

  // feature sum update and first layer activations
  always_ff @(posedge clk) begin
    if (p1_v && state == nbe_pkg::B_FEAT) begin
      fs_mem[p1_j] <= fs_base + 32'(iw_q);
    end
  end

  always_ff @(posedge clk) begin
    if (p1_v && state == nbe_pkg::B_H1) begin
      h1_mem[p1_j] <= nbe_pkg::clip_act(34'(b1_q) + 34'(fs_base));
    end
  end

  // feature sum valid bits, cleared after each evaluate
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_vld <= '0;
    end else if (load_out) begin
      fs_vld <= '0;
    end else if (p1_v && state == nbe_pkg::B_FEAT) begin
      fs_vld[p1_j] <= 1'b1;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= iss;
      p2_v <= p1_v && (state == nbe_pkg::B_L2 || state == nbe_pkg::B_OUT);
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    if (state == nbe_pkg::B_OUT) begin
      op_a = h2_q;
      op_b = ow_q;
    end else begin
      op_a = h1_q;
      op_b = w2_q;
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    p2_prod  <= $signed({1'b0, op_a}) * op_b;
    p2_bias  <= (state == nbe_pkg::B_OUT) ? ob : b2_q;
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_i     <= p1_i;
  end

  // floor shift and accumulate
  assign mac_sum = (p2_first ? 32'(p2_bias) : acc) +
                   32'(p2_prod >>> nbe_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (p2_v) begin
      acc <= mac_sum;
      if (p2_last && state == nbe_pkg::B_L2) begin
        h2[p2_i] <= nbe_pkg::clip_act(34'(mac_sum));
      end
      if (p2_last && state == nbe_pkg::B_OUT) begin
        out_val <= mac_sum;
      end
    end
  end

  // score scaling
  always_ff @(posedge clk) begin
    if (state == nbe_pkg::B_SCALE) begin
      prod_s <= 43'(out_val) * 43'(nbe_pkg::SCORE_SCALE);
    end
  end

  // truncate toward zero, saturate, negate for black, zero if weights not ready
  always_comb begin
    q_div = (prod_s + (prod_s[42] ? 43'sd4095 : 43'sd0)) >>> nbe_pkg::FRAC_BITS;
    if (q_div > 43'(nbe_pkg::SCORE_LIMIT)) begin
      score_next = 16'(nbe_pkg::SCORE_LIMIT);
    end else if (q_div < -43'(nbe_pkg::SCORE_LIMIT)) begin
      score_next = -16'(nbe_pkg::SCORE_LIMIT);
    end else begin
      score_next = q_div[15:0];
    end
    if (ev_black) begin
      score_next = -score_next;
    end
    if (!ev_ready) begin
      score_next = 16'sd0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      score <= score_next;
    end
  end

endmodule

// ===== rtl/core/nnue_board_evaluator.sv =====
// Top level: 768-256-32-1 board evaluation network
// A feature adds its weight row to the feature sums, one row entry per cycle.
// Evaluate: 256 bias adds, then 8192 layer-two products and 32 output products
// on the single shared multiply-accumulate, then scale and saturate.
// One item runs in the back end at a time; a 4-entry queue takes items meanwhile.
// Reset clears control, feature count and feature-sum valid bits; weights keep their contents.
module nnue_board_evaluator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [2:0]         table_select,
  input  logic [17:0]        weight_index,
  input  logic signed [15:0] weight_value,
  input  logic [3:0]         piece,
  input  logic [5:0]         square,
  input  logic               side_to_move,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] score,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic         weights_ready;
  logic         q_full;
  logic         push;
  logic         pop;
  logic         q_valid;
  nbe_pkg::op_t op_in;
  nbe_pkg::op_t op_out;

  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      weights_ready <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      weights_ready <= cfg_data;
    end
  end

  nbe_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .table_select  (table_select),
    .weight_index  (weight_index),
    .weight_value  (weight_value),
    .piece         (piece),
    .square        (square),
    .side_to_move  (side_to_move),
    .weights_ready (weights_ready),
    .q_full        (q_full),
    .push          (push),
    .op            (op_in)
  );

  nbe_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .op_in  (op_in),
    .full   (q_full),
    .pop    (pop),
    .valid  (q_valid),
    .op_out (op_out)
  );

  nbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_op      (op_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .score     (score)
  );

endmodule

// ===== rtl/core/nbe_checker.sv =====
// port-level checks of the board evaluator and their binding
module nbe_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] score,
  input logic               cfg_ready
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(score))
    else $error("stalled result changed");

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // saturation never yields the most negative code
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> score != 16'sh8000)
    else $error("score out of saturated range");

  // config port never blocks
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind nnue_board_evaluator nbe_checker u_nbe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .score     (score),
  .cfg_ready (cfg_ready)
);
